@@ hdl/pss_pkg.sv @@
package pss_pkg;

  // position lanes: x, y, z
  localparam int unsigned NUM_AXES = 3;

  // heading constants, unsigned Q9.7 degrees
  localparam logic [15:0] HDG_FULL = 16'd46080;
  localparam logic signed [17:0] TURN_S = 18'sd46080;
  localparam logic signed [17:0] HALF_S = 18'sd23040;

  // smoothing gain after reset, about 0.30 in Q0.16
  localparam logic [15:0] GAIN_RESET = 16'd19661;

  // half of the Q0.16 scale, used for rounding to nearest
  localparam logic [15:0] ROUND_HALF = 16'd32768;

  // one slot's held pose as stored in the slot memory
  typedef struct packed {
    logic [15:0]                  hdg;
    logic [NUM_AXES-1:0][31:0]    pos;
  } pose_t;

endpackage

@@ hdl/per_slot_pose_smoother.sv @@
// A word passes the read, multiply and update stages and then the output register to m_axis.
// Throughput: one word per cycle unless m_axis stalls; an active word whose slot matches an
//   active word in the multiply or update stage is held in the read stage for its write-back.
// The slot memory is read at the edge that accepts a word and written from the update stage.
// Reset: pipeline empty, all slots unprimed, gain back to 19661; slot memory is not cleared,
//   since the first active word of a slot overwrites it.
module per_slot_pose_smoother #(
  parameter int NUM_SLOTS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // gain register, unsigned Q0.16
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // raw_x [31:0], raw_y [63:32], raw_z [95:64], raw_heading [111:96]
  input  logic [111:0] s_axis_tdata,
  // slot_index [2:0], peer_active [3]
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // smooth_x [31:0], smooth_y [63:32], smooth_z [95:64], smooth_heading [111:96]
  output logic [111:0] m_axis_tdata,
  // out_slot [2:0], out_valid [3]
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);
  import pss_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // configuration
  logic [15:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // pipeline handshake
  logic a_v_q, b_v_q, c_v_q, out_v_q;
  logic a_move, b_move, c_move, out_free, b_free, c_free, a_free;
  logic hazard, s_fire;

  assign out_free      = !out_v_q || m_axis_tready;
  assign c_move        = c_v_q && out_free;
  assign c_free        = !c_v_q || c_move;
  assign b_move        = b_v_q && c_free;
  assign b_free        = !b_v_q || b_move;
  assign a_move        = a_v_q && b_free && !hazard;
  assign a_free        = !a_v_q || a_move;
  assign s_axis_tready = a_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // input unpacking
  logic [2:0] in_slot;
  pose_t      in_raw;

  always_comb begin
    in_slot        = s_axis_tuser[2:0];
    in_raw.pos[0]  = s_axis_tdata[31:0];
    in_raw.pos[1]  = s_axis_tdata[63:32];
    in_raw.pos[2]  = s_axis_tdata[95:64];
    in_raw.hdg     = s_axis_tdata[111:96];
  end

  // read stage registers
  logic [2:0] a_slot_q;
  logic       a_act_q;
  pose_t      a_raw_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_slot_q <= in_slot;
      a_act_q  <= s_axis_tuser[3];
      a_raw_q  <= in_raw;
    end
  end

  // slot addresses
  logic [AW+2:0] in_slot_ext, a_slot_ext, c_slot_ext;
  logic [AW-1:0] in_addr, a_addr, c_addr, raddr;
  logic [2:0]    c_slot_q;

  assign in_slot_ext = {{AW{1'b0}}, in_slot};
  assign a_slot_ext  = {{AW{1'b0}}, a_slot_q};
  assign c_slot_ext  = {{AW{1'b0}}, c_slot_q};
  assign in_addr     = in_slot_ext[AW-1:0];
  assign a_addr      = a_slot_ext[AW-1:0];
  assign c_addr      = c_slot_ext[AW-1:0];

  // a stalled word keeps re-reading its own slot
  assign raddr = (a_v_q && !a_move) ? a_addr : in_addr;

  // slot memory with write-through bypass for same-edge read and write
  pose_t mem_q [NUM_SLOTS];
  pose_t rd_q, byp_q, wdata;
  logic  mem_we, byp_hit_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[c_addr] <= wdata;
    end
    rd_q  <= mem_q[raddr];
    byp_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else begin
      byp_hit_q <= mem_we && (c_addr == raddr);
    end
  end

  // primed flags, updated as a word leaves the read stage
  logic [NUM_SLOTS-1:0] primed_q;
  logic                 a_inr, a_wr, snap;

  assign a_inr = (32'(a_slot_q) < 32'(NUM_SLOTS));
  assign a_wr  = a_act_q && a_inr;
  assign snap  = !primed_q[a_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
    end else if (a_move && a_inr) begin
      primed_q[a_addr] <= a_act_q;
    end
  end

  // hold a word while an older write to its slot is still in flight
  logic [2:0] b_slot_q;
  logic       b_wr_q, c_wr_q;

  assign hazard = a_wr && ((b_v_q && b_wr_q && (b_slot_q == a_slot_q)) ||
                           (c_v_q && c_wr_q && (c_slot_q == a_slot_q)));

  // read stage: gaps and their magnitudes
  pose_t                     held, a_base;
  logic [NUM_AXES-1:0]       a_neg;
  logic [NUM_AXES-1:0][32:0] a_mag;
  logic [15:0]               a_rh;
  logic signed [17:0]        hg0, hg;
  logic                      a_hneg;
  logic [17:0]               h_abs;
  logic [14:0]               a_hmag;

  always_comb begin
    logic [32:0] d_rh, d_hr;
    held = byp_hit_q ? byp_q : rd_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      d_rh = {a_raw_q.pos[i][31], a_raw_q.pos[i]} - {held.pos[i][31], held.pos[i]};
      d_hr = {held.pos[i][31], held.pos[i]} - {a_raw_q.pos[i][31], a_raw_q.pos[i]};
      a_neg[i]      = d_rh[32] && !snap;
      a_mag[i]      = snap ? 33'd0 : (d_rh[32] ? d_hr : d_rh);
      a_base.pos[i] = snap ? a_raw_q.pos[i] : held.pos[i];
    end
    // raw heading reduced below a full turn
    a_rh = (a_raw_q.hdg >= HDG_FULL) ? (a_raw_q.hdg - HDG_FULL) : a_raw_q.hdg;
    // heading gap, short way around the circle
    hg0 = $signed({2'b00, a_rh}) - $signed({2'b00, held.hdg});
    if (hg0 > HALF_S) begin
      hg = hg0 - TURN_S;
    end else if (hg0 < -HALF_S) begin
      hg = hg0 + TURN_S;
    end else begin
      hg = hg0;
    end
    h_abs      = hg[17] ? 18'(-hg) : 18'(hg);
    a_hneg     = hg[17] && !snap;
    a_hmag     = snap ? 15'd0 : h_abs[14:0];
    a_base.hdg = snap ? a_rh : held.hdg;
  end

  // multiply stage registers
  pose_t                     b_base_q;
  logic [NUM_AXES-1:0]       b_neg_q;
  logic [NUM_AXES-1:0][32:0] b_mag_q;
  logic                      b_hneg_q;
  logic [14:0]               b_hmag_q;

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_slot_q <= a_slot_q;
      b_base_q <= a_base;
      b_neg_q  <= a_neg;
      b_mag_q  <= a_mag;
      b_hneg_q <= a_hneg;
      b_hmag_q <= a_hmag;
    end
  end

  // step magnitudes, rounded to nearest
  logic [NUM_AXES-1:0][32:0] b_q;
  logic [14:0]               b_hq;

  always_comb begin
    logic [48:0] prod;
    logic [30:0] hprod;
    for (int i = 0; i < NUM_AXES; i++) begin
      prod   = 49'(b_mag_q[i]) * 49'(gain_q) + 49'(ROUND_HALF);
      b_q[i] = prod[48:16];
    end
    hprod = 31'(b_hmag_q) * 31'(gain_q) + 31'(ROUND_HALF);
    b_hq  = hprod[30:16];
  end

  // update stage registers
  pose_t                     c_base_q;
  logic [NUM_AXES-1:0]       c_neg_q;
  logic [NUM_AXES-1:0][32:0] c_q_q;
  logic                      c_hneg_q;
  logic [14:0]               c_hq_q;

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      c_slot_q <= b_slot_q;
      c_base_q <= b_base_q;
      c_neg_q  <= b_neg_q;
      c_q_q    <= b_q;
      c_hneg_q <= b_hneg_q;
      c_hq_q   <= b_hq;
    end
  end

  // new held values and wrapped heading
  logic signed [17:0] hs_add, hs_sub, hs;

  always_comb begin
    logic [33:0] base_ext, s_add, s_sub;
    for (int i = 0; i < NUM_AXES; i++) begin
      base_ext     = {{2{c_base_q.pos[i][31]}}, c_base_q.pos[i]};
      s_add        = base_ext + {1'b0, c_q_q[i]};
      s_sub        = base_ext - {1'b0, c_q_q[i]};
      wdata.pos[i] = c_neg_q[i] ? s_sub[31:0] : s_add[31:0];
    end
    hs_add = $signed({2'b00, c_base_q.hdg}) + $signed({3'b000, c_hq_q});
    hs_sub = $signed({2'b00, c_base_q.hdg}) - $signed({3'b000, c_hq_q});
    hs     = c_hneg_q ? hs_sub : hs_add;
    if (hs < 18'sd0) begin
      wdata.hdg = 16'(hs + TURN_S);
    end else if (hs >= TURN_S) begin
      wdata.hdg = 16'(hs - TURN_S);
    end else begin
      wdata.hdg = hs[15:0];
    end
  end

  assign mem_we = c_move && c_wr_q;

  // output register
  logic [2:0] out_slot_q;
  logic       out_act_q;
  pose_t      out_pose_q;

  always_ff @(posedge clk_i) begin
    if (c_move) begin
      out_slot_q <= c_slot_q;
      out_act_q  <= c_wr_q;
      out_pose_q <= c_wr_q ? wdata : '0;
    end
  end

  // stage valids and write flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      b_wr_q  <= 1'b0;
      c_wr_q  <= 1'b0;
    end else begin
      a_v_q   <= s_fire || (a_v_q && !a_move);
      b_v_q   <= a_move || (b_v_q && !b_move);
      c_v_q   <= b_move || (c_v_q && !c_move);
      out_v_q <= c_move || (out_v_q && !m_axis_tready);
      if (a_move) begin
        b_wr_q <= a_wr;
      end
      if (b_move) begin
        c_wr_q <= b_wr_q;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = {out_act_q, out_slot_q};
  assign m_axis_tdata  = {out_pose_q.hdg, out_pose_q.pos[2], out_pose_q.pos[1],
                          out_pose_q.pos[0]};

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (wdata.hdg < HDG_FULL))
    else $error("heading written back outside one turn");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(c_slot_q) < 32'(NUM_SLOTS)))
    else $error("slot memory written for a slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && a_wr) |=> primed_q[$past(a_addr)])
    else $error("active word did not prime its slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[3]) |-> (m_axis_tdata == '0))
    else $error("released or ignored slot returned nonzero pose");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && a_wr && b_v_q && b_wr_q) |-> (b_slot_q != a_slot_q))
    else $error("read stage passed an in-flight write to its own slot");

endmodule

@@ tb/sv/pose_checker.sv @@
module pose_checker #(
  parameter int NUM_SLOTS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // raw_x [31:0], raw_y [63:32], raw_z [95:64], raw_heading [111:96]
  input  logic [111:0] s_axis_tdata,
  // slot_index [2:0], peer_active [3]
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // smooth_x [31:0], smooth_y [63:32], smooth_z [95:64], smooth_heading [111:96]
  input  logic [111:0] m_axis_tdata,
  // out_slot [2:0], out_valid [3]
  input  logic [3:0]   m_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output int           mismatch_count_o,
  output int           outstanding_o
);
  import pss_pkg::*;

  typedef struct packed {
    logic [2:0] slot;
    logic       live;
    pose_t      pose;
  } slot_result_t;

  // mirror of the block's slot memory and gain register
  pose_t        held_pose [NUM_SLOTS];
  logic         primed    [NUM_SLOTS];
  logic [15:0]  gain;
  slot_result_t smoothed_q [$];
  slot_result_t want;
  pose_t        got_pose;

  // gain times gap in Q0.16, rounded to nearest, ties away from zero
  function automatic longint gain_step(longint gap, logic [15:0] g);
    longint mag;
    longint q;
    mag = (gap < 0) ? -gap : gap;
    q = (mag * longint'(g) + longint'(ROUND_HALF)) >>> 16;
    return (gap < 0) ? -q : q;
  endfunction

  function automatic logic [31:0] ease_coord(logic signed [31:0] cur,
                                             logic signed [31:0] tgt,
                                             logic [15:0] g);
    longint next;
    next = longint'(cur) + gain_step(longint'(tgt) - longint'(cur), g);
    return next[31:0];
  endfunction

  // heading gap takes the short way, exact half turn kept as is
  function automatic logic [15:0] ease_heading(logic [15:0] cur, logic [15:0] tgt,
                                               logic [15:0] g);
    longint gap;
    longint next;
    gap = longint'(tgt) - longint'(cur);
    if (gap > longint'(HALF_S)) gap = gap - longint'(TURN_S);
    if (gap < -longint'(HALF_S)) gap = gap + longint'(TURN_S);
    next = longint'(cur) + gain_step(gap, g);
    if (next < 0) next = next + longint'(TURN_S);
    if (next >= longint'(TURN_S)) next = next - longint'(TURN_S);
    return next[15:0];
  endfunction

  // update one slot and return the word the block should emit
  function automatic slot_result_t advance_slot(logic [2:0] slot, logic active, pose_t raw);
    slot_result_t res;
    res = '0;
    res.slot = slot;
    if (raw.hdg >= HDG_FULL) raw.hdg = raw.hdg - HDG_FULL;
    if (slot >= NUM_SLOTS) return res;
    if (!active) begin
      primed[slot] = 1'b0;
      return res;
    end
    if (!primed[slot]) begin
      held_pose[slot] = raw;
      primed[slot] = 1'b1;
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        held_pose[slot].pos[a] = ease_coord(held_pose[slot].pos[a], raw.pos[a], gain);
      end
      held_pose[slot].hdg = ease_heading(held_pose[slot].hdg, raw.hdg, gain);
    end
    res.live = 1'b1;
    res.pose = held_pose[slot];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatch_count_o++;
    end
  endtask

  initial mismatch_count_o = 0;

  // watch both channels and the gain port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain = GAIN_RESET;
      smoothed_q.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        held_pose[i] = '0;
        primed[i] = 1'b0;
      end
    end else begin
      // output word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (smoothed_q.size() == 0) begin
          $display("%0t: output word with no prediction waiting, actual %h %h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = smoothed_q.pop_front();
          got_pose = m_axis_tdata;
          check_field("out_slot", want.slot, m_axis_tuser[2:0]);
          check_field("out_valid", want.live, m_axis_tuser[3]);
          for (int a = 0; a < NUM_AXES; a++) begin
            check_field($sformatf("smooth_pos[%0d]", a), want.pose.pos[a], got_pose.pos[a]);
          end
          check_field("smooth_heading", want.pose.hdg, got_pose.hdg);
        end
      end
      // input word
      if (s_axis_tvalid && s_axis_tready) begin
        smoothed_q.push_back(advance_slot(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata));
      end
      // gain write takes effect for later words
      if (cfg_we_i) gain = cfg_wdata_i;
    end
    outstanding_o = smoothed_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import pss_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES = 10;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic [111:0] s_axis_tdata;
  logic [3:0]   s_axis_tuser;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  int           mismatch_count;
  int           outstanding;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_off_request;

  per_slot_pose_smoother #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  pose_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_request) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_request = 1'b0;
      end
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one word, entered and left at a falling edge
  task automatic send_word(input logic [2:0] slot, input logic active,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [15:0] hdg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {hdg, z, y, x};
    s_axis_tuser = {active, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // gain written only once every word has come back
  task automatic write_gain(input logic [15:0] g);
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = g;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd23040;
      2: return 16'd46079;
      3: return 16'($urandom_range(65535, 46080));
      default: return 16'($urandom_range(46079));
    endcase
  endfunction

  // mostly live samples on random slots, some releases
  task automatic run_random(input int count, input int hold_off_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_off_at) hold_off_request = 1'b1;
      send_word(3'($urandom_range(NUM_SLOTS - 1)), $urandom_range(99) >= 8,
                pick_coord(), pick_coord(), pick_coord(), pick_heading());
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    send_idle_pct = 32;
    recv_idle_pct = 73;
    hold_off_request = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words at the reset gain
    // extremes, full-width position gap, heading gap across zero
    send_word(0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd0);
    send_word(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd46079);
    send_word(0, 1, 32'h0, 32'h0, 32'h0, 16'd100);
    // heading at or above a full turn
    send_word(1, 1, 32'h1, 32'hFFFF_FFFF, 32'd12345678, 16'd65535);
    send_word(1, 1, 32'h1, 32'hFFFF_FFFF, 32'd12345678, 16'd46080);
    // gap of exactly half a turn, both signs
    send_word(2, 1, 32'h0, 32'h0, 32'h0, 16'd0);
    send_word(2, 1, 32'h0, 32'h0, 32'h0, 16'd23040);
    send_word(3, 1, 32'h0, 32'h0, 32'h0, 16'd23040);
    send_word(3, 1, 32'h0, 32'h0, 32'h0, 16'd0);
    // short way across zero, upward and downward
    send_word(4, 1, 32'h10000, 32'h20000, 32'h30000, 16'd45990);
    send_word(4, 1, 32'h10000, 32'h20000, 32'h30000, 16'd50);
    send_word(5, 1, -32'sd5, 32'd5, 32'h0, 16'd100);
    send_word(5, 1, 32'd5, -32'sd5, 32'h0, 16'd46000);
    // release and re-prime
    send_word(0, 0, 32'hDEAD_BEEF, 32'h1234_5678, 32'h8765_4321, 16'd777);
    send_word(0, 1, 32'd12345, -32'sd12345, 32'h4000_0000, 16'd9000);
    send_word(0, 1, 32'd0, 32'd0, 32'hC000_0000, 16'd35000);
    // release of a slot never primed
    send_word(6, 0, 32'h0, 32'h0, 32'h0, 16'd0);
    send_word(6, 1, 32'hFFFF_0000, 32'h0001_0000, 32'h7FFF_FFFF, 16'd46079);
    send_word(7, 1, 32'h0, 32'h0, 32'h0, 16'd0);
    send_word(7, 1, 32'd5, -32'sd5, 32'd1, 16'd1);
    send_word(7, 1, -32'sd5, 32'd5, -32'sd1, 16'd46079);

    // sender idles less than the receiver
    write_gain(16'd65535);
    run_random(300, 120);
    write_gain(16'd1);
    run_random(300, -1);

    // receiver idles less than the sender
    send_idle_pct = 73;
    recv_idle_pct = 32;
    write_gain(16'd0);
    run_random(150, -1);
    write_gain(16'($urandom_range(65535, 1)));
    run_random(450, -1);

    // no random idling on either side, with one receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gain(16'd32768);
    run_random(450, 200);

    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
